// ===== design/backtracking_maze_carver_unit_assert.svh =====
// Assertion macros for the maze carver checker.
`ifndef BACKTRACKING_MAZE_CARVER_UNIT_ASSERT_SVH
`define BACKTRACKING_MAZE_CARVER_UNIT_ASSERT_SVH

// Checked on every clock edge outside reset.
`define BMC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define BMC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== design/bmc_pkg.sv =====
// Shared constants, codes and types of the maze carver.
package bmc_pkg;

   localparam int MAX_COLS   = 32;
   localparam int MAX_ROWS   = 32;
   localparam int COL_W      = $clog2(MAX_COLS);
   localparam int ROW_W      = $clog2(MAX_ROWS);
   localparam int CELL_W     = COL_W + ROW_W;
   localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;
   localparam int STK_AW     = $clog2(CELL_COUNT);
   localparam int DEPTH_W    = $clog2(CELL_COUNT + 1);

   localparam int DIM_W = 6;
   localparam logic [DIM_W-1:0] DIM_RESET = 6'd32;

   localparam int RAND_W    = 16;
   localparam int MOD_DIGIT = 4;
   localparam int MOD_STEPS = RAND_W / MOD_DIGIT;
   localparam int MOD_CNT_W = $clog2(MOD_STEPS);

   localparam int COORD_MAX_W = (COL_W > ROW_W) ? COL_W : ROW_W;
   localparam int CMP_W       = ((COORD_MAX_W > DIM_W) ? COORD_MAX_W : DIM_W) + 1;

   localparam int REQ_TYPE_W  = 1;
   localparam int OUT_COORD_W = 5;
   localparam int SIDE_W      = 2;
   localparam int STATUS_W    = 2;
   localparam int RSP_DATA_W  = 16;
   localparam int RSP_PAD_W   = RSP_DATA_W - 2 * OUT_COORD_W - SIDE_W;
   localparam int CSR_INDEX_W = 1;

   localparam logic [REQ_TYPE_W-1:0] REQ_BEGIN = 1'b0;

   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_HEIGHT = 1'b1;

   typedef enum logic [SIDE_W-1:0] {
      SIDE_NORTH,
      SIDE_EAST,
      SIDE_SOUTH,
      SIDE_WEST
   } side_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_CARVED,
      STATUS_ENTRANCE,
      STATUS_EXIT,
      STATUS_IGNORED
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_BMOD,
      S_RD0,
      S_RD1,
      S_RD2,
      S_RD3,
      S_EVAL,
      S_POP,
      S_XMOD,
      S_OUT
   } state_type;

endpackage

// ===== design/backtracking_maze_carver_unit.sv =====
// Top level of the depth-first maze carver: sequencer, path stack and visited-row memory.
//
// Channel  Direction  Handshake              Payload (low bit up)
// req      in         req_tvalid/req_tready  tuser: req_type; tdata: random_word
// rsp      out        rsp_tvalid/rsp_tready  tdata: cell_x, cell_y, wall_side; tuser: status
// csr      in         csr_valid/csr_ready    csr_index selects register, csr_data value
//
// Item timing is set by the visited-row memory's one read port (three row reads per stack
// top, again for each cell backtracked) and by the remainder unit used at begin and at the
// final (exit) step.
// Reset is synchronous; no clearing pass, row valid bits are all dropped together at begin.
// A result stalled at rsp holds the sequencer at its next result; the next item can be taken while it waits.
module backtracking_maze_carver_unit import bmc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TYPE_W-1:0]  req_tuser,   // req_type
   input  logic [RAND_W-1:0]      req_tdata,   // random_word
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // cell_x[4:0], cell_y[9:5], wall_side[11:10]
   output logic [STATUS_W-1:0]    rsp_tuser,   // status
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]       csr_data
);

   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v, input int max_dim);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (int'(v) > max_dim) begin
         r = DIM_W'(max_dim);
      end
      return r;
   endfunction

   // out-of-range row (above top or below last) maps to row 0; neighbour tests mask it
   function automatic logic [ROW_W-1:0] row_wrap(input logic [ROW_W:0] v);
      logic [ROW_W-1:0] r;
      r = v[ROW_W-1:0];
      if (int'(v) >= MAX_ROWS) begin
         r = '0;
      end
      return r;
   endfunction

   // 4 = 1 mod 3, so the sum of base-4 digits keeps the residue
   function automatic logic [1:0] mod3(input logic [RAND_W-1:0] v);
      logic [4:0] s;
      logic [2:0] t;
      s = '0;
      for (int i = 0; i < RAND_W / 2; i++) begin
         s = s + 5'(v[2*i +: 2]);
      end
      t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
      if (t >= 3'd6) begin
         t = t - 3'd6;
      end else if (t >= 3'd3) begin
         t = t - 3'd3;
      end
      return t[1:0];
   endfunction

   function automatic logic [RSP_DATA_W-1:0] pack_rsp(input logic [OUT_COORD_W-1:0] x,
                                                      input logic [OUT_COORD_W-1:0] y,
                                                      input side_type side);
      return {RSP_PAD_W'(0), side, y, x};
   endfunction

   state_type             state_ff, state_in;
   logic [DIM_W-1:0]      grid_width_ff, grid_height_ff;
   logic                  active_ff, active_in;
   logic [DEPTH_W-1:0]    depth_ff, depth_in;
   logic [MAX_ROWS-1:0]   row_valid_ff, row_valid_in;
   logic [CELL_W-1:0]     cur_ff, cur_in;
   logic [RAND_W-1:0]     rnd_ff, rnd_in;
   logic [1:0]            rmod3_ff, rmod3_in;
   logic [MAX_COLS-1:0]   row_c_ff, row_c_in;
   logic [MAX_COLS-1:0]   row_n_ff, row_n_in;
   logic [MAX_COLS-1:0]   row_s_ff, row_s_in;
   logic [RSP_DATA_W-1:0] res_tdata_ff, res_tdata_in;
   logic [STATUS_W-1:0]   res_tuser_ff, res_tuser_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic [STATUS_W-1:0]   rsp_tuser_ff, rsp_tuser_in;

   logic [DIM_W-1:0]    eff_w, eff_h;
   logic [COL_W-1:0]    cx, cx_p1, cx_m1;
   logic [ROW_W-1:0]    cy, row_up, row_dn;
   logic [CMP_W-1:0]    xe, ye, we, he;
   logic [3:0]          avail;
   logic [2:0]          n_open;
   logic [1:0]          pick;
   side_type            sel_dir;
   logic [COL_W-1:0]    nb_x;
   logic [ROW_W-1:0]    nb_y;
   logic [MAX_COLS-1:0] nb_row;
   logic [DEPTH_W-1:0]  depth_m2;
   logic [ROW_W-1:0]    mod_row;

   logic                mod_start, mod_done;
   logic [RAND_W-1:0]   mod_dividend;
   logic [DIM_W-1:0]    mod_rem;

   logic                vis_wr_en, vis_rd_en;
   logic [ROW_W-1:0]    vis_wr_addr, vis_rd_addr;
   logic [MAX_COLS-1:0] vis_wr_data, vis_rd_data;
   logic                stk_wr_en, stk_rd_en;
   logic [STK_AW-1:0]   stk_wr_addr, stk_rd_addr;
   logic [CELL_W-1:0]   stk_wr_data, stk_rd_data;

   assign eff_w = eff_dim(grid_width_ff, MAX_COLS);
   assign eff_h = eff_dim(grid_height_ff, MAX_ROWS);

   assign cx     = cur_ff[COL_W-1:0];
   assign cy     = cur_ff[CELL_W-1:COL_W];
   assign cx_p1  = cx + COL_W'(1);
   assign cx_m1  = cx - COL_W'(1);
   assign row_up = row_wrap({1'b0, cy} - (ROW_W + 1)'(1));
   assign row_dn = row_wrap({1'b0, cy} + (ROW_W + 1)'(1));
   assign xe     = CMP_W'(cx);
   assign ye     = CMP_W'(cy);
   assign we     = CMP_W'(eff_w);
   assign he     = CMP_W'(eff_h);

   assign depth_m2 = depth_ff - DEPTH_W'(2);
   assign mod_row  = ROW_W'(mod_rem);

   // open neighbours of the stack top and the chosen one
   always_comb begin
      logic [1:0] cnt;
      logic       found;
      avail[SIDE_NORTH] = (ye != '0) && ((ye - CMP_W'(1)) < he) && (xe < we) && !row_n_ff[cx];
      avail[SIDE_EAST]  = ((xe + CMP_W'(1)) < we) && (ye < he) && !row_c_ff[cx_p1];
      avail[SIDE_SOUTH] = ((ye + CMP_W'(1)) < he) && (xe < we) && !row_s_ff[cx];
      avail[SIDE_WEST]  = (xe != '0) && ((xe - CMP_W'(1)) < we) && (ye < he) && !row_c_ff[cx_m1];
      n_open = 3'($countones(avail));
      case (n_open)
         3'd2:    pick = {1'b0, rnd_ff[0]};
         3'd3:    pick = rmod3_ff;
         3'd4:    pick = rnd_ff[1:0];
         default: pick = 2'd0;
      endcase
      cnt     = 2'd0;
      found   = 1'b0;
      sel_dir = SIDE_NORTH;
      for (int d = 0; d < 4; d++) begin
         if (avail[d] && !found) begin
            if (cnt == pick) begin
               sel_dir = side_type'(SIDE_W'(d));
               found   = 1'b1;
            end
            cnt = cnt + 2'd1;
         end
      end
      nb_x   = cx;
      nb_y   = cy;
      nb_row = row_c_ff;
      unique case (sel_dir)
         SIDE_NORTH: begin
            nb_y   = cy - ROW_W'(1);
            nb_row = row_n_ff;
         end
         SIDE_EAST: begin
            nb_x = cx_p1;
         end
         SIDE_SOUTH: begin
            nb_y   = cy + ROW_W'(1);
            nb_row = row_s_ff;
         end
         SIDE_WEST: begin
            nb_x = cx_m1;
         end
         default: begin
            nb_x = cx;
         end
      endcase
   end

   assign mod_dividend = (state_ff == S_IDLE) ? req_tdata : rnd_ff;

   // sequencer: each visited-row write lands before any later read is issued,
   // so the memories need no forwarding
   always_comb begin
      state_in     = state_ff;
      active_in    = active_ff;
      depth_in     = depth_ff;
      row_valid_in = row_valid_ff;
      cur_in       = cur_ff;
      rnd_in       = rnd_ff;
      rmod3_in     = rmod3_ff;
      row_c_in     = row_c_ff;
      row_n_in     = row_n_ff;
      row_s_in     = row_s_ff;
      res_tdata_in = res_tdata_ff;
      res_tuser_in = res_tuser_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_tdata_in = rsp_tdata_ff;
      rsp_tuser_in = rsp_tuser_ff;
      req_tready   = 1'b0;
      mod_start    = 1'b0;
      vis_rd_en    = 1'b0;
      vis_rd_addr  = cy;
      vis_wr_en    = 1'b0;
      vis_wr_addr  = nb_y;
      vis_wr_data  = nb_row | (MAX_COLS'(1) << nb_x);
      stk_rd_en    = 1'b0;
      stk_rd_addr  = depth_m2[STK_AW-1:0];
      stk_wr_en    = 1'b0;
      stk_wr_addr  = depth_ff[STK_AW-1:0];
      stk_wr_data  = {nb_y, nb_x};

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               rnd_in   = req_tdata;
               rmod3_in = mod3(req_tdata);
               if (req_tuser == REQ_BEGIN) begin
                  mod_start = 1'b1;
                  state_in  = S_BMOD;
               end else if (!active_ff) begin
                  res_tdata_in = pack_rsp('0, '0, SIDE_NORTH);
                  res_tuser_in = STATUS_IGNORED;
                  state_in     = S_OUT;
               end else begin
                  state_in = S_RD0;
               end
            end
         end
         S_BMOD: begin
            if (mod_done) begin
               row_valid_in          = '0;
               row_valid_in[mod_row] = 1'b1;
               vis_wr_en             = 1'b1;
               vis_wr_addr           = mod_row;
               vis_wr_data           = MAX_COLS'(1);
               stk_wr_en             = 1'b1;
               stk_wr_addr           = '0;
               stk_wr_data           = {mod_row, COL_W'(0)};
               depth_in              = DEPTH_W'(1);
               cur_in                = {mod_row, COL_W'(0)};
               active_in             = 1'b1;
               res_tdata_in = pack_rsp('0, OUT_COORD_W'(mod_rem), SIDE_WEST);
               res_tuser_in = STATUS_ENTRANCE;
               state_in     = S_OUT;
            end
         end
         S_RD0: begin
            vis_rd_en   = 1'b1;
            vis_rd_addr = cy;
            state_in    = S_RD1;
         end
         S_RD1: begin
            row_c_in    = vis_rd_data & {MAX_COLS{row_valid_ff[cy]}};
            vis_rd_en   = 1'b1;
            vis_rd_addr = row_up;
            state_in    = S_RD2;
         end
         S_RD2: begin
            row_n_in    = vis_rd_data & {MAX_COLS{row_valid_ff[row_up]}};
            vis_rd_en   = 1'b1;
            vis_rd_addr = row_dn;
            state_in    = S_RD3;
         end
         S_RD3: begin
            row_s_in = vis_rd_data & {MAX_COLS{row_valid_ff[row_dn]}};
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (n_open != 3'd0) begin
               vis_wr_en          = 1'b1;
               row_valid_in[nb_y] = 1'b1;
               // a full stack keeps its top; the neighbour is still marked
               if (depth_ff < DEPTH_W'(CELL_COUNT)) begin
                  stk_wr_en = 1'b1;
                  depth_in  = depth_ff + DEPTH_W'(1);
                  cur_in    = {nb_y, nb_x};
               end
               res_tdata_in = pack_rsp(OUT_COORD_W'(cx), OUT_COORD_W'(cy), sel_dir);
               res_tuser_in = STATUS_CARVED;
               state_in     = S_OUT;
            end else begin
               depth_in = depth_ff - DEPTH_W'(1);
               if (depth_ff == DEPTH_W'(1)) begin
                  mod_start = 1'b1;
                  active_in = 1'b0;
                  state_in  = S_XMOD;
               end else begin
                  stk_rd_en = 1'b1;
                  state_in  = S_POP;
               end
            end
         end
         S_POP: begin
            cur_in   = stk_rd_data;
            state_in = S_RD0;
         end
         S_XMOD: begin
            if (mod_done) begin
               res_tdata_in = pack_rsp(OUT_COORD_W'(eff_w - DIM_W'(1)),
                                       OUT_COORD_W'(mod_rem), SIDE_EAST);
               res_tuser_in = STATUS_EXIT;
               state_in     = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_tdata_in = res_tdata_ff;
               rsp_tuser_in = res_tuser_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         active_ff    <= 1'b0;
         depth_ff     <= '0;
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         depth_ff     <= depth_in;
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= DIM_RESET;
         grid_height_ff <= DIM_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_GRID_WIDTH:  grid_width_ff  <= csr_data;
            CSR_GRID_HEIGHT: grid_height_ff <= csr_data;
            default:         grid_width_ff  <= grid_width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      rnd_ff       <= rnd_in;
      rmod3_ff     <= rmod3_in;
      row_c_ff     <= row_c_in;
      row_n_ff     <= row_n_in;
      row_s_ff     <= row_s_in;
      res_tdata_ff <= res_tdata_in;
      res_tuser_ff <= res_tuser_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   bmc_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (mod_dividend),
      .divisor   (eff_h),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   bmc_ram #(
      .WIDTH (MAX_COLS),
      .DEPTH (MAX_ROWS)
   ) u_visit_ram (
      .clock   (clock),
      .wr_en   (vis_wr_en),
      .wr_addr (vis_wr_addr),
      .wr_data (vis_wr_data),
      .rd_en   (vis_rd_en),
      .rd_addr (vis_rd_addr),
      .rd_data (vis_rd_data)
   );

   bmc_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELL_COUNT)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_en   (stk_rd_en),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

// ===== design/bmc_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM with registered read.
module bmc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/bmc_mod.sv =====
// Iterative remainder unit: random word modulo a small divisor, four bits a cycle.
module bmc_mod import bmc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [RAND_W-1:0] dividend,
   input  logic [DIM_W-1:0]  divisor,
   output logic              done,
   output logic [DIM_W-1:0]  remainder
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [MOD_CNT_W-1:0] cnt_ff, cnt_in;
   logic [RAND_W-1:0]    shift_ff, shift_in;
   logic [DIM_W-1:0]     rem_ff, rem_in;
   logic [DIM_W-1:0]     div_ff, div_in;

   always_comb begin
      logic [DIM_W:0] acc;
      acc      = {1'b0, rem_ff};
      for (int i = 0; i < MOD_DIGIT; i++) begin
         acc = {acc[DIM_W-1:0], shift_ff[RAND_W-1-i]};
         if (acc >= {1'b0, div_ff}) begin
            acc = acc - {1'b0, div_ff};
         end
      end
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         shift_in = dividend;
         rem_in   = '0;
         div_in   = divisor;
      end else if (busy_ff) begin
         rem_in   = acc[DIM_W-1:0];
         shift_in = shift_ff << MOD_DIGIT;
         cnt_in   = cnt_ff + MOD_CNT_W'(1);
         if (cnt_ff == MOD_CNT_W'(MOD_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== design/bmc_checker.sv =====
// Port-level checker for the maze carver, bound to the top level.
`include "backtracking_maze_carver_unit_assert.svh"

module bmc_checker import bmc_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [REQ_TYPE_W-1:0]  req_tuser,
   input logic [RAND_W-1:0]      req_tdata,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_DATA_W-1:0]  rsp_tdata,
   input logic [STATUS_W-1:0]    rsp_tuser,
   input logic                   csr_valid,
   input logic                   csr_ready,
   input logic [CSR_INDEX_W-1:0] csr_index,
   input logic [DIM_W-1:0]       csr_data
);

   // no result is shown right after reset
   `BMC_ASSERT_ALWAYS(a_rsp_idle_after_reset, reset |=> !rsp_tvalid, "rsp valid after reset")

   // one item at a time: taking an item closes the input for the next cycle
   `BMC_ASSERT(a_one_item_in_work, req_tvalid && req_tready |=> !req_tready, "req taken twice")

   // a stalled result keeps its payload
   `BMC_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled rsp changed")

   // ignored steps carry an all-zero payload
   `BMC_ASSERT(a_ignored_zero, rsp_tvalid && rsp_tuser == STATUS_IGNORED |-> rsp_tdata == '0, "ignored item with payload")

   // entrance is always the west wall of column zero
   `BMC_ASSERT(a_entrance_west, rsp_tvalid && rsp_tuser == STATUS_ENTRANCE |-> rsp_tdata[4:0] == '0 && rsp_tdata[11:10] == SIDE_WEST, "bad entrance")

endmodule

bind backtracking_maze_carver_unit bmc_checker u_checker (.*);
